@@ src/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the priority pixel compositor.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int BLOCK_W     = 9;
  localparam int CID_W       = 6;
  localparam int COMP_W      = 8;
  localparam int RGB_W       = 3 * COMP_W;
  localparam int TIME_W      = 32;
  localparam int LEN_W       = 10;
  localparam int OP_W        = 2;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int S_TDATA_W   = 112;
  localparam int M_TDATA_W   = 40;
  localparam int QUEUE_DEPTH = 2;

  // input operations
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_ENTRY = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OUTSIDE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN  = 2'd3;

  localparam logic [BLOCK_W-1:0] RST_FIRST_BASE  = 9'd100;
  localparam logic [LEN_W-1:0]   RST_FIRST_LEN   = 10'd128;
  localparam logic [BLOCK_W-1:0] RST_SECOND_BASE = 9'd300;
  localparam logic [LEN_W-1:0]   RST_SECOND_LEN  = 10'd128;

  typedef struct packed {
    logic [BLOCK_W-1:0] first_base;
    logic [LEN_W-1:0]   first_len;
    logic [BLOCK_W-1:0] second_base;
    logic [LEN_W-1:0]   second_len;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BLOCK_W-1:0] block;
    logic               beyond;
    logic [CID_W-1:0]   color_id;
    logic               pal_ok;
    logic [RGB_W-1:0]   rgb;
  } cmd_t;

endpackage

@@ src/ppc_ram.sv @@
// ----------------------------------------------------------------------------
// ppc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ppc_queue.sv @@
// ----------------------------------------------------------------------------
// ppc_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ppc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ppc_pkg::cmd_t din,
  output logic          ready,
  input  logic          pop,
  output ppc_pkg::cmd_t dout,
  output logic          valid
);

  localparam int PTR_W = $clog2(ppc_pkg::QUEUE_DEPTH);

  ppc_pkg::cmd_t    entries [ppc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign ready = (count != (PTR_W+1)'(ppc_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/ppc_front.sv @@
// ----------------------------------------------------------------------------
// ppc_front
// Accepts input items, latches the frame time and picks each entry's block.
// ----------------------------------------------------------------------------
module ppc_front #(
  parameter int BLOCK_COUNT     = 512,
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ppc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic [ppc_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                            init_busy,
  input  logic                            q_ready,
  output logic                            q_push,
  output ppc_pkg::cmd_t                   q_cmd
);

  logic [ppc_pkg::TIME_W-1:0]  frame_epoch;
  logic [ppc_pkg::TIME_W-1:0]  frame_time;
  logic [ppc_pkg::BLOCK_W-1:0] pre_block;
  logic [ppc_pkg::BLOCK_W-1:0] post_block;
  logic [ppc_pkg::TIME_W-1:0]  event_time;
  logic [ppc_pkg::CID_W-1:0]   color_id;
  logic [ppc_pkg::RGB_W-1:0]   rgb;
  logic [ppc_pkg::BLOCK_W-1:0] block;
  logic                        accept;

  assign frame_time = s_axis_tdata[31:0];
  assign pre_block  = s_axis_tdata[40:32];
  assign post_block = s_axis_tdata[49:41];
  assign event_time = s_axis_tdata[81:50];
  assign color_id   = s_axis_tdata[87:82];
  // stored as red in the top byte
  assign rgb        = {s_axis_tdata[95:88], s_axis_tdata[103:96], s_axis_tdata[111:104]};

  assign s_axis_tready = q_ready && !init_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign block = (frame_epoch >= event_time) ? post_block : pre_block;

  always_comb begin
    q_cmd.op       = s_axis_tuser;
    q_cmd.block    = block;
    q_cmd.beyond   = (int'(block) >= BLOCK_COUNT);
    q_cmd.color_id = color_id;
    q_cmd.pal_ok   = (int'(color_id) < PALETTE_ENTRIES);
    q_cmd.rgb      = rgb;
  end

  // unused op code is swallowed here
  assign q_push = accept && (s_axis_tuser == ppc_pkg::OP_BEGIN ||
                             s_axis_tuser == ppc_pkg::OP_ENTRY ||
                             s_axis_tuser == ppc_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_epoch <= '0;
    end else if (accept && s_axis_tuser == ppc_pkg::OP_BEGIN) begin
      frame_epoch <= frame_time;
    end
  end

endmodule

@@ src/ppc_back.sv @@
// ----------------------------------------------------------------------------
// ppc_back
// Executes queued commands against the priority store and the palette and
// drives the result register.
// ----------------------------------------------------------------------------
module ppc_back #(
  parameter int BLOCK_COUNT     = 512,
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppc_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  ppc_pkg::cmd_t                 q_head,
  output logic                          q_pop,
  output logic                          init_busy,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ppc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [ppc_pkg::KIND_W-1:0]    m_axis_tuser
);

  localparam int ADDR_W = $clog2(BLOCK_COUNT);
  localparam int PAL_W  = $clog2(PALETTE_ENTRIES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BLOCK_COUNT - 1);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_MARK  = 5'b10000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [ADDR_W-1:0]             clr_addr;
  logic [ADDR_W-1:0]             clr_addr_next;
  ppc_pkg::cmd_t                 cmd;
  logic                          cmd_load;

  logic                          st_we;
  logic [ADDR_W-1:0]             st_waddr;
  logic [ppc_pkg::CID_W-1:0]     st_wdata;
  logic                          st_re;
  logic [ppc_pkg::CID_W-1:0]     st_rdata;
  logic                          pal_we;
  logic                          pal_re;
  logic [ppc_pkg::RGB_W-1:0]     pal_rdata;

  logic                          out_free;
  logic                          out_load;
  logic [ppc_pkg::KIND_W-1:0]    out_kind;
  logic [ppc_pkg::M_TDATA_W-1:0] out_data;

  logic                          on_first;
  logic                          on_second;
  logic [ppc_pkg::BLOCK_W-1:0]   pix_first;
  logic [ppc_pkg::BLOCK_W-1:0]   pix_second;
  logic [ppc_pkg::RGB_W-1:0]     color;
  logic                          dropped;

  ppc_ram #(
    .WIDTH (ppc_pkg::CID_W),
    .DEPTH (BLOCK_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (ADDR_W'(q_head.block)),
    .rdata (st_rdata)
  );

  ppc_ram #(
    .WIDTH (ppc_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (PAL_W'(q_head.color_id)),
    .wdata (q_head.rgb),
    .re    (pal_re),
    .raddr (PAL_W'(q_head.color_id)),
    .rdata (pal_rdata)
  );

  // strand mapping, full width compare so long strands work
  assign on_first  = (cmd.block >= cfg.first_base) &&
                     ({2'b00, cmd.block} < ({2'b00, cfg.first_base} + {1'b0, cfg.first_len}));
  assign on_second = (cmd.block >= cfg.second_base) &&
                     ({2'b00, cmd.block} < ({2'b00, cfg.second_base} + {1'b0, cfg.second_len}));
  assign pix_first  = cmd.block - cfg.first_base;
  assign pix_second = cmd.block - cfg.second_base;
  assign color      = cmd.pal_ok ? pal_rdata : '0;
  assign dropped    = (cmd.color_id < st_rdata);

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign init_busy = (state == ST_INIT);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    cmd_load      = 1'b0;
    q_pop         = 1'b0;
    st_we         = 1'b0;
    st_waddr      = clr_addr;
    st_wdata      = '0;
    st_re         = 1'b0;
    pal_we        = 1'b0;
    pal_re        = 1'b0;
    out_load      = 1'b0;
    out_kind      = ppc_pkg::KIND_OUTSIDE;
    out_data      = '0;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        st_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = (state == ST_CLEAR) ? ST_MARK : ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_load = 1'b1;
          unique case (q_head.op)
            ppc_pkg::OP_BEGIN: begin
              clr_addr_next = '0;
              state_next    = ST_CLEAR;
            end
            ppc_pkg::OP_ENTRY: begin
              st_re      = 1'b1;
              pal_re     = 1'b1;
              state_next = ST_EXEC;
            end
            ppc_pkg::OP_LOAD: begin
              pal_we = q_head.pal_ok;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (cmd.beyond) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (dropped) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          st_we      = 1'b1;
          st_waddr   = ADDR_W'(cmd.block);
          st_wdata   = cmd.color_id;
          out_load   = 1'b1;
          state_next = ST_IDLE;
          priority if (on_first) begin
            out_kind = ppc_pkg::KIND_PIXEL;
            out_data = {6'b0, color[7:0], color[15:8], color[23:16], pix_first, 1'b0};
          end else if (on_second) begin
            out_kind = ppc_pkg::KIND_PIXEL;
            out_data = {6'b0, color[7:0], color[15:8], color[23:16], pix_second, 1'b1};
          end else begin
            out_kind = ppc_pkg::KIND_OUTSIDE;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind   = ppc_pkg::KIND_CLEAR;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd <= q_head;
    end
    if (out_load) begin
      m_axis_tuser <= out_kind;
      m_axis_tdata <= out_data;
    end
  end

endmodule

@@ src/priority_pixel_compositor.sv @@
// ----------------------------------------------------------------------------
// priority_pixel_compositor
// Composites scheduled block colours onto two LED strands by priority.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: frame_time, pre_block, post_block,
//                                        event_time, color_id, red_in, green_in,
//                                        blue_in; tuser: op
//  m_axis    out  tvalid/tready          tdata: strand, pixel, red_out, green_out,
//                                        blue_out; tuser: kind
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
//  schedule entry in the back: priority store read, then compare/write
//  palette load: a palette write; begin frame: a clearing sweep of the priority
//  store, one entry per cycle, then a frame clear marker
//  after reset a clearing sweep of the whole priority store runs with s_axis_tready low
//  a two-entry command queue lets the front keep accepting while the back works
//  or waits on m_axis_tready; the result register holds while stalled
//
module priority_pixel_compositor #(
  parameter int BLOCK_COUNT     = 512,
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // frame_time, pre_block, post_block, event_time, color_id, red_in, green_in, blue_in
  input  logic [ppc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [ppc_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // strand, pixel, red_out, green_out, blue_out, zero pad
  output logic [ppc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // kind
  output logic [ppc_pkg::KIND_W-1:0]       m_axis_tuser,
  input  logic                             cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ppc_pkg::cfg_t cfg;
  ppc_pkg::cmd_t q_cmd;
  ppc_pkg::cmd_t q_head;
  logic          q_push;
  logic          q_ready;
  logic          q_pop;
  logic          q_valid;
  logic          init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_base  <= ppc_pkg::RST_FIRST_BASE;
      cfg.first_len   <= ppc_pkg::RST_FIRST_LEN;
      cfg.second_base <= ppc_pkg::RST_SECOND_BASE;
      cfg.second_len  <= ppc_pkg::RST_SECOND_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppc_pkg::CFG_FIRST_BASE:  cfg.first_base  <= cfg_data[8:0];
        ppc_pkg::CFG_FIRST_LEN:   cfg.first_len   <= cfg_data;
        ppc_pkg::CFG_SECOND_BASE: cfg.second_base <= cfg_data[8:0];
        ppc_pkg::CFG_SECOND_LEN:  cfg.second_len  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ppc_front #(
    .BLOCK_COUNT     (BLOCK_COUNT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .init_busy     (init_busy),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  ppc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_cmd),
    .ready (q_ready),
    .pop   (q_pop),
    .dout  (q_head),
    .valid (q_valid)
  );

  ppc_back #(
    .BLOCK_COUNT     (BLOCK_COUNT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // no result can leave while the store is still being swept after reset
  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !m_axis_tvalid)
    else $error("result produced during reset sweep");

  // a frame clear marker carries an all-zero payload
  a_clear_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ppc_pkg::KIND_CLEAR) |-> (m_axis_tdata == '0))
    else $error("frame clear marker with non-zero payload");

  // the queue is never pushed when full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("command queue overflow");

endmodule

@@ tb/priority_pixel_compositor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_pixel_compositor_tb
// Drives begin-frame, palette-load and schedule-entry transactions into the
// compositor under several strand layouts. A local priority and palette model
// predicts every strand update, and each result is checked field by field.
// ----------------------------------------------------------------------------
module priority_pixel_compositor_tb;
  import ppc_pkg::*;

  localparam int BLOCK_COUNT     = 512;
  localparam int PALETTE_ENTRIES = 64;
  localparam int SETTLE_CYCLES   = BLOCK_COUNT + 88;
  localparam int MAX_CYCLES      = 2_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // packed from the top down, so frame_time lands in the lowest bits
  typedef struct packed {
    logic [COMP_W-1:0]  blue_in;
    logic [COMP_W-1:0]  green_in;
    logic [COMP_W-1:0]  red_in;
    logic [CID_W-1:0]   color_id;
    logic [TIME_W-1:0]  event_time;
    logic [BLOCK_W-1:0] post_block;
    logic [BLOCK_W-1:0] pre_block;
    logic [TIME_W-1:0]  frame_time;
  } sched_fields_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    sched_fields_t   f;
  } sched_item_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [COMP_W-1:0]  blue;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  red;
    logic [BLOCK_W-1:0] pixel;
    logic               strand;
  } px_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               strand;
    logic [BLOCK_W-1:0] pixel;
    logic [RGB_W-1:0]   rgb;
  } strand_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  priority_pixel_compositor #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // local copy of the compositor state
  logic [CID_W-1:0]  prio_level [BLOCK_COUNT];
  logic [RGB_W-1:0]  swatch [PALETTE_ENTRIES];
  logic [TIME_W-1:0] latched_epoch = '0;
  cfg_t lane_cfg = '{RST_FIRST_BASE, RST_FIRST_LEN, RST_SECOND_BASE, RST_SECOND_LEN};

  sched_item_t    cmd_backlog [$];
  strand_update_t updates_due [$];
  int mismatches = 0;
  int cycle_count = 0;
  int gap_pct = 20;
  int stall_pct = 20;

  // generator-side view, used to keep entries well formed
  logic [TIME_W-1:0] gen_epoch = '0;
  int loaded_ids [$];
  int hot_blocks [$];

  sched_item_t    drv_item;
  px_word_t       got_word;
  strand_update_t want;

  initial begin
    foreach (prio_level[i]) prio_level[i] = '0;
    foreach (swatch[i]) swatch[i] = '0;
  end

  task automatic report_mismatch(input string detail);
    if (mismatches < 100) $display("mismatch at cycle %0d: %s", cycle_count, detail);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  function automatic bit covers(input int blk, input int base, input int len);
    return blk >= base && blk < base + len;
  endfunction

  task automatic composite_item(input logic [OP_W-1:0] op, input sched_fields_t f);
    int blk;
    logic [RGB_W-1:0] rgb;
    strand_update_t u;
    u = '0;
    case (op)
      OP_BEGIN: begin
        latched_epoch = f.frame_time;
        foreach (prio_level[i]) prio_level[i] = '0;
        u.kind = KIND_CLEAR;
        updates_due.insert(updates_due.size(), u);
      end
      OP_LOAD: begin
        if (f.color_id < PALETTE_ENTRIES)
          swatch[f.color_id] = {f.red_in, f.green_in, f.blue_in};
      end
      OP_ENTRY: begin
        blk = (latched_epoch >= f.event_time) ? int'(f.post_block) : int'(f.pre_block);
        if (blk >= BLOCK_COUNT) begin
          u.kind = KIND_OUTSIDE;
          updates_due.insert(updates_due.size(), u);
        end else if (f.color_id >= prio_level[blk]) begin
          prio_level[blk] = f.color_id;
          rgb = (f.color_id < PALETTE_ENTRIES) ? swatch[f.color_id] : '0;
          if (covers(blk, lane_cfg.first_base, lane_cfg.first_len)) begin
            u.kind   = KIND_PIXEL;
            u.strand = 1'b0;
            u.pixel  = BLOCK_W'(blk - int'(lane_cfg.first_base));
            u.rgb    = rgb;
          end else if (covers(blk, lane_cfg.second_base, lane_cfg.second_len)) begin
            u.kind   = KIND_PIXEL;
            u.strand = 1'b1;
            u.pixel  = BLOCK_W'(blk - int'(lane_cfg.second_base));
            u.rgb    = rgb;
          end else begin
            u.kind = KIND_OUTSIDE;
          end
          updates_due.insert(updates_due.size(), u);
        end
      end
      default: ;
    endcase
  endtask

  // driver: next transaction once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        drv_item = cmd_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= drv_item.f;
        s_axis_tuser  <= drv_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_BASE:  lane_cfg.first_base  = cfg_data[BLOCK_W-1:0];
          CFG_FIRST_LEN:   lane_cfg.first_len   = cfg_data[LEN_W-1:0];
          CFG_SECOND_BASE: lane_cfg.second_base = cfg_data[BLOCK_W-1:0];
          CFG_SECOND_LEN:  lane_cfg.second_len  = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_word = m_axis_tdata;
        if (updates_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", m_axis_tuser));
        end else begin
          want = updates_due.pop_front();
          check_field("kind", m_axis_tuser, want.kind);
          check_field("strand", got_word.strand, want.strand);
          check_field("pixel", got_word.pixel, want.pixel);
          check_field("red", got_word.red, want.rgb[23:16]);
          check_field("green", got_word.green, want.rgb[15:8]);
          check_field("blue", got_word.blue, want.rgb[7:0]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        composite_item(s_axis_tuser, sched_fields_t'(s_axis_tdata));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic sched_item_t mk_item(input logic [OP_W-1:0] op,
                                          input logic [TIME_W-1:0] ftime,
                                          input logic [BLOCK_W-1:0] pre,
                                          input logic [BLOCK_W-1:0] post,
                                          input logic [TIME_W-1:0] etime,
                                          input logic [CID_W-1:0] cid,
                                          input logic [RGB_W-1:0] rgb);
    sched_item_t it;
    it.op           = op;
    it.f.frame_time = ftime;
    it.f.pre_block  = pre;
    it.f.post_block = post;
    it.f.event_time = etime;
    it.f.color_id   = cid;
    it.f.red_in     = rgb[23:16];
    it.f.green_in   = rgb[15:8];
    it.f.blue_in    = rgb[7:0];
    return it;
  endfunction

  task automatic push_item(input sched_item_t it);
    int hits[$];
    if (it.op == OP_BEGIN) gen_epoch = it.f.frame_time;
    if (it.op == OP_LOAD) begin
      hits = loaded_ids.find_index with (item == int'(it.f.color_id));
      if (hits.size() == 0) loaded_ids.insert(loaded_ids.size(), int'(it.f.color_id));
    end
    cmd_backlog.insert(cmd_backlog.size(), it);
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    if ($urandom_range(0, 1) == 0) return BLOCK_W'($urandom_range(0, BLOCK_COUNT - 1));
    return BLOCK_W'(hot_blocks[$urandom_range(0, hot_blocks.size() - 1)]);
  endfunction

  task automatic add_random_item();
    sched_item_t it;
    int pick;
    it = mk_item(OP_ENTRY, $urandom, pick_block(), pick_block(), $urandom,
                 CID_W'(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)]),
                 RGB_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.op = OP_BEGIN;
      case ($urandom_range(0, 9))
        0: it.f.frame_time = '0;
        1: it.f.frame_time = '1;
        default: ;
      endcase
    end else if (pick < 20) begin
      it.op = OP_LOAD;
      it.f.color_id = CID_W'($urandom_range(0, PALETTE_ENTRIES - 1));
    end else if (pick >= 95) begin
      it.op = OP_UNUSED;
    end else begin
      // keep event times near the frame time so both blocks get chosen
      case ($urandom_range(0, 4))
        0: it.f.event_time = '0;
        1: it.f.event_time = gen_epoch;
        2: it.f.event_time = gen_epoch + 1;
        3: it.f.event_time = gen_epoch - 1;
        default: ;
      endcase
    end
    push_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || updates_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int b0, input int l0, input int b1, input int l1,
                           input int n, input int gap, input int stall,
                           input bit pause_midway);
    wait_idle();
    // an entry with no result or a clearing sweep may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_cfg(CFG_FIRST_BASE, b0);
    write_cfg(CFG_FIRST_LEN, l0);
    write_cfg(CFG_SECOND_BASE, b1);
    write_cfg(CFG_SECOND_LEN, l1);
    gap_pct   = gap;
    stall_pct = stall;
    hot_blocks.delete();
    foreach (hot_blocks[i]) ;
    hot_blocks = '{b0 & 511, (b0 + l0 - 1) & 511, (b0 + l0) & 511, (b0 - 1) & 511,
                   b1 & 511, (b1 + l1 - 1) & 511, (b1 + l1) & 511, (b1 - 1) & 511,
                   $urandom_range(0, 511), $urandom_range(0, 511),
                   $urandom_range(0, 511), $urandom_range(0, 511)};
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) wait_idle();
      add_random_item();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_item(mk_item(OP_LOAD, '0, '0, '0, '0, 6'd0, 24'hFFFFFF));
    push_item(mk_item(OP_LOAD, '1, 9'd511, 9'd511, '1, 6'd63, 24'h000000));
    push_item(mk_item(OP_LOAD, '0, '0, '0, '0, 6'd21, 24'hA55A3C));
    push_item(mk_item(OP_LOAD, '0, '0, '0, '0, 6'd42, 24'h5AA5C3));
    // zero event time always takes the post block
    push_item(mk_item(OP_ENTRY, '0, 9'd0, 9'd100, '0, 6'd21, '0));
    push_item(mk_item(OP_BEGIN, 32'd1000, '0, '0, '0, 6'd0, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd0, 9'd227, 32'd1000, 6'd0, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd300, 9'd0, 32'd1001, 6'd63, '0));
    // lower id on the same block is dropped, equal id goes through
    push_item(mk_item(OP_ENTRY, '0, 9'd300, 9'd0, 32'd1001, 6'd21, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd300, 9'd0, 32'd1001, 6'd63, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd0, 9'd0, '0, 6'd0, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd0, 9'd511, '0, 6'd63, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd0, 9'd99, '0, 6'd42, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd0, 9'd228, '0, 6'd42, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd427, 9'd0, '1, 6'd42, '0));
    push_item(mk_item(OP_UNUSED, '1, 9'd511, 9'd300, '0, 6'd21, 24'hFFFFFF));
    push_item(mk_item(OP_BEGIN, '1, '0, '0, '0, 6'd0, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd100, 9'd428, '1, 6'd21, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd0, 9'd300, '0, 6'd0, '0));
    push_item(mk_item(OP_BEGIN, '0, '0, '0, '0, 6'd0, '0));
    push_item(mk_item(OP_ENTRY, '0, 9'd101, 9'd0, 32'd1, 6'd63, '0));

    run_phase(100, 128, 300, 128, 200, 20, 20, 1'b1);
    // strands overlap, the first one wins
    run_phase(200, 512, 0, 512, 200, 20, 20, 1'b0);
    // empty first strand, single-pixel second strand, no idling on either side
    run_phase(511, 0, 511, 1, 200, 0, 0, 1'b0);
    run_phase(0, 512, 511, 512, 200, 20, 20, 1'b0);
    run_phase($urandom_range(0, 511), $urandom_range(0, 512),
              $urandom_range(0, 511), $urandom_range(0, 512), 200, 20, 20, 1'b0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (updates_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", updates_due.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
